FILE: src/fdlf_pkg.sv
// Shared constants and types for the focus drift line fit block.
package fdlf_pkg;

    localparam int TIME_BITS     = 20;
    localparam int POSITION_BITS = 16;
    localparam int OFFSET_BITS   = 16;
    localparam int WEIGHT_BITS   = 24;
    localparam int SUM_BITS      = 48;
    localparam int MOMENT_BITS   = 64;
    localparam int SLOPE_BITS    = 32;
    localparam int ANCHOR_BITS   = 28;
    localparam int MOVE_BITS     = 18;
    localparam int MUL_BITS      = 64;
    localparam int WIDE_BITS     = 128;
    localparam int MUL_STEPS     = 64;
    localparam int DIV_STEPS     = 128;
    localparam int CNT_BITS      = 8;
    localparam int IN_DATA_BITS  = 72;
    localparam int OUT_DATA_BITS = 80;
    localparam int OUT_USER_BITS = 3;

    localparam logic REQ_ADD     = 1'b0;
    localparam logic REQ_PREDICT = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_NO_MODEL   = 2'd1,
        STATUS_DEGENERATE = 2'd2
    } fit_status_t;

endpackage

FILE: src/focus_drift_line_fit.sv
// Focus drift line fit: weighted least-squares fit with a bit-serial multiplier and divider.
//
// Channel  | Direction | Payload
// s_axis   | in        | tdata: sample_time, measured_position, filter_offset, current_position
//          |           | tuser: req_type
// m_axis   | out       | tdata: drift_rate, reference_position, move_delta
//          |           | tuser: model_valid, fit_status
//
// A full add runs six 64-bit shift-add products and two 128-bit restoring divisions
// before the result register is loaded. A degenerate add stops after two products, a
// predict runs one product, and the first add and a predict without a model run none.
// Reset clears all sums and the model; one request is in work at a time.
// A stalled result waits in the output register; the next request is taken meanwhile.
module focus_drift_line_fit
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // sample_time, measured_position, filter_offset, current_position, zero pad.
    input  logic [fdlf_pkg::IN_DATA_BITS-1:0]      s_axis_tdata,
    // req_type.
    input  logic                                   s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // drift_rate, reference_position, move_delta, zero pad.
    output logic [fdlf_pkg::OUT_DATA_BITS-1:0]     m_axis_tdata,
    // model_valid, fit_status.
    output logic [fdlf_pkg::OUT_USER_BITS-1:0]     m_axis_tuser
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_MUL_Q1,
        ST_MUL_Q2,
        ST_MUL_P1,
        ST_MUL_P2,
        ST_DIV_SLOPE,
        ST_MUL_TW,
        ST_MUL_CORR,
        ST_DIV_ANCHOR,
        ST_PRED_SETUP,
        ST_MUL_PRED,
        ST_MOVE,
        ST_FINISH
    } state_t;

    state_t state_reg;
    logic [fdlf_pkg::CNT_BITS-1:0] cnt_reg;

    logic [19:0]  t_reg;
    logic [15:0]  p_reg;
    logic [15:0]  cur_reg;
    logic [15:0]  off_reg;
    logic [35:0]  tp_reg;
    logic [39:0]  tt_reg;

    logic         have_model_reg;
    logic [23:0]  w_reg;
    logic [47:0]  sx_reg;
    logic [47:0]  sy_reg;
    logic [63:0]  sxy_reg;
    logic [63:0]  sxx_reg;
    logic [31:0]  slope_reg;
    logic [27:0]  anchor_reg;
    logic [19:0]  atime_reg;

    logic [127:0] acc1_reg;
    logic [127:0] acc2_reg;
    logic         neg_reg;
    logic [31:0]  slope_new_reg;
    logic [57:0]  x_reg;
    logic [17:0]  mv_reg;
    fdlf_pkg::fit_status_t status_reg;

    logic [63:0]  mcand_reg;
    logic [128:0] prod_reg;
    logic [127:0] num_reg;
    logic [127:0] dvs_reg;
    logic [127:0] rem_reg;
    logic [127:0] quo_reg;

    logic                                   m_tvalid_reg;
    logic [fdlf_pkg::OUT_DATA_BITS-1:0]     m_tdata_reg;
    logic [fdlf_pkg::OUT_USER_BITS-1:0]     m_tuser_reg;

    logic [23:0]  w_upd;
    logic [47:0]  sx_upd;
    logic [47:0]  sy_upd;
    logic [63:0]  sxy_upd;
    logic [63:0]  sxx_upd;

    logic         mul_state;
    logic         div_state;
    logic         mul_run;
    logic         div_run;
    logic [64:0]  mul_add;
    logic [128:0] prod_next;
    logic [127:0] product;

    logic [127:0] rem_shift;
    logic         div_ge;
    logic [127:0] rem_next;
    logic [127:0] quo_next;
    logic [127:0] q_fin;
    logic [128:0] q_round;
    logic [127:0] rq;
    logic         slope_ovf_pos;
    logic         slope_ovf_neg;
    logic         anchor_ovf_pos;
    logic         anchor_ovf_neg;
    logic [31:0]  slope_sat;
    logic [27:0]  anchor_sat;

    logic [20:0]  dt;
    logic [20:0]  dt_mag;
    logic [31:0]  slope_mag;
    logic [31:0]  slope_new_mag;
    logic [49:0]  b_val;
    logic [49:0]  b_mag;
    logic [127:0] a_val;
    logic [127:0] tot_val;
    logic         tot_neg;
    logic [57:0]  sp_val;
    logic [57:0]  x_val;
    logic signed [39:0] mv_full;
    logic [17:0]  mv_sat;

    assign w_upd   = (w_reg >> 1) + 24'h10_0000;
    assign sx_upd  = (sx_reg >> 1) + {8'd0, t_reg, 20'd0};
    assign sy_upd  = (sy_reg >> 1) + {12'd0, p_reg, 20'd0};
    assign sxy_upd = (sxy_reg >> 1) + {8'd0, tp_reg, 20'd0};
    assign sxx_upd = (sxx_reg >> 1) + {4'd0, tt_reg, 20'd0};

    assign mul_state = (state_reg == ST_MUL_Q1) || (state_reg == ST_MUL_Q2) ||
                       (state_reg == ST_MUL_P1) || (state_reg == ST_MUL_P2) ||
                       (state_reg == ST_MUL_TW) || (state_reg == ST_MUL_CORR) ||
                       (state_reg == ST_MUL_PRED);
    assign div_state = (state_reg == ST_DIV_SLOPE) || (state_reg == ST_DIV_ANCHOR);
    assign mul_run   = mul_state && (cnt_reg != fdlf_pkg::CNT_BITS'(fdlf_pkg::MUL_STEPS));
    assign div_run   = div_state && (cnt_reg != fdlf_pkg::CNT_BITS'(fdlf_pkg::DIV_STEPS));

    assign mul_add   = {1'b0, prod_reg[127:64]} + (prod_reg[0] ? {1'b0, mcand_reg} : 65'd0);
    assign prod_next = {1'b0, mul_add, prod_reg[63:1]};
    assign product   = prod_reg[127:0];

    assign rem_shift = {rem_reg[126:0], num_reg[127]};
    assign div_ge    = rem_shift >= dvs_reg;
    assign rem_next  = div_ge ? rem_shift - dvs_reg : rem_shift;
    assign quo_next  = {quo_reg[126:0], div_ge};
    assign q_fin     = (dvs_reg == 128'd0) ? 128'd0 : quo_reg;
    assign q_round   = {1'b0, q_fin} + 129'd1;
    assign rq        = q_round[128:1];

    assign slope_ovf_pos  = |rq[127:31];
    assign slope_ovf_neg  = (|rq[127:32]) || (rq[31] && (|rq[30:0]));
    assign anchor_ovf_pos = |rq[127:27];
    assign anchor_ovf_neg = (|rq[127:28]) || (rq[27] && (|rq[26:0]));
    assign slope_sat  = neg_reg ? (slope_ovf_neg ? 32'h8000_0000 : 32'd0 - rq[31:0])
                                : (slope_ovf_pos ? 32'h7FFF_FFFF : rq[31:0]);
    assign anchor_sat = neg_reg ? (anchor_ovf_neg ? 28'h800_0000 : 28'd0 - rq[27:0])
                                : (anchor_ovf_pos ? 28'h7FF_FFFF : rq[27:0]);

    assign dt            = {1'b0, t_reg} - {1'b0, atime_reg};
    assign dt_mag        = dt[20] ? 21'd0 - dt : dt;
    assign slope_mag     = slope_reg[31] ? 32'd0 - slope_reg : slope_reg;
    assign slope_new_mag = slope_new_reg[31] ? 32'd0 - slope_new_reg : slope_new_reg;
    assign b_val         = {6'd0, product[43:0]} - {2'd0, sx_reg};
    assign b_mag         = b_val[49] ? 50'd0 - b_val : b_val;

    assign a_val = {60'd0, sy_reg, 20'd0};
    always_comb
    begin
        tot_neg = 1'b0;
        if (!neg_reg)
        begin
            tot_val = a_val + product;
        end
        else if (a_val >= product)
        begin
            tot_val = a_val - product;
        end
        else
        begin
            tot_val = product - a_val;
            tot_neg = 1'b1;
        end
    end

    assign sp_val  = neg_reg ? 58'd0 - {5'd0, product[52:0]} : {5'd0, product[52:0]};
    assign x_val   = {{18{anchor_reg[27]}}, anchor_reg, 12'd0} + sp_val + 58'd524288;
    assign mv_full = {{2{x_reg[57]}}, x_reg[57:20]} + {{24{off_reg[15]}}, off_reg}
                     - {24'd0, cur_reg};
    assign mv_sat  = (mv_full > 40'sd131071)  ? 18'h1_FFFF :
                     (mv_full < -40'sd131072) ? 18'h2_0000 : mv_full[17:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            have_model_reg <= 1'b0;
            w_reg          <= '0;
            sx_reg         <= '0;
            sy_reg         <= '0;
            sxy_reg        <= '0;
            sxx_reg        <= '0;
            slope_reg      <= '0;
            anchor_reg     <= '0;
            atime_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            if (mul_run)
            begin
                prod_reg <= prod_next;
                cnt_reg  <= cnt_reg + 1'b1;
            end
            if (div_run)
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                num_reg <= {num_reg[126:0], 1'b0};
                cnt_reg <= cnt_reg + 1'b1;
            end
            if ((state_reg == ST_FINISH) && (!m_tvalid_reg || m_axis_tready))
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_axis_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        t_reg   <= s_axis_tdata[19:0];
                        p_reg   <= s_axis_tdata[35:20];
                        off_reg <= s_axis_tdata[51:36];
                        cur_reg <= s_axis_tdata[67:52];
                        tp_reg  <= s_axis_tdata[19:0] * s_axis_tdata[35:20];
                        tt_reg  <= s_axis_tdata[19:0] * s_axis_tdata[19:0];
                        mv_reg  <= '0;
                        if (s_axis_tuser == fdlf_pkg::REQ_ADD)
                        begin
                            state_reg <= ST_UPDATE;
                        end
                        else if (!have_model_reg)
                        begin
                            status_reg <= fdlf_pkg::STATUS_NO_MODEL;
                            state_reg  <= ST_FINISH;
                        end
                        else
                        begin
                            state_reg <= ST_PRED_SETUP;
                        end
                    end
                end
                ST_UPDATE:
                begin
                    w_reg      <= w_upd;
                    sx_reg     <= sx_upd;
                    sy_reg     <= sy_upd;
                    sxy_reg    <= sxy_upd;
                    sxx_reg    <= sxx_upd;
                    status_reg <= fdlf_pkg::STATUS_OK;
                    if (!have_model_reg)
                    begin
                        have_model_reg <= 1'b1;
                        slope_reg      <= '0;
                        anchor_reg     <= {4'd0, p_reg, 8'd0};
                        atime_reg      <= t_reg;
                        state_reg      <= ST_FINISH;
                    end
                    else
                    begin
                        mcand_reg <= {40'd0, w_upd};
                        prod_reg  <= {65'd0, sxx_upd};
                        cnt_reg   <= '0;
                        state_reg <= ST_MUL_Q1;
                    end
                end
                ST_MUL_Q1:
                begin
                    if (!mul_run)
                    begin
                        acc1_reg  <= product;
                        mcand_reg <= {16'd0, sx_reg};
                        prod_reg  <= {81'd0, sx_reg};
                        cnt_reg   <= '0;
                        state_reg <= ST_MUL_Q2;
                    end
                end
                ST_MUL_Q2:
                begin
                    if (!mul_run)
                    begin
                        if ((acc1_reg <= product) || (w_reg == 24'd0))
                        begin
                            status_reg <= fdlf_pkg::STATUS_DEGENERATE;
                            state_reg  <= ST_FINISH;
                        end
                        else
                        begin
                            acc1_reg  <= acc1_reg - product;
                            mcand_reg <= {40'd0, w_reg};
                            prod_reg  <= {65'd0, sxy_reg};
                            cnt_reg   <= '0;
                            state_reg <= ST_MUL_P1;
                        end
                    end
                end
                ST_MUL_P1:
                begin
                    if (!mul_run)
                    begin
                        acc2_reg  <= product;
                        mcand_reg <= {16'd0, sx_reg};
                        prod_reg  <= {81'd0, sy_reg};
                        cnt_reg   <= '0;
                        state_reg <= ST_MUL_P2;
                    end
                end
                ST_MUL_P2:
                begin
                    if (!mul_run)
                    begin
                        neg_reg <= acc2_reg < product;
                        if (acc2_reg < product)
                        begin
                            num_reg <= (product - acc2_reg) << 21;
                        end
                        else
                        begin
                            num_reg <= (acc2_reg - product) << 21;
                        end
                        dvs_reg   <= acc1_reg;
                        rem_reg   <= '0;
                        quo_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_DIV_SLOPE;
                    end
                end
                ST_DIV_SLOPE:
                begin
                    if (!div_run)
                    begin
                        slope_new_reg <= slope_sat;
                        mcand_reg     <= {44'd0, t_reg};
                        prod_reg      <= {105'd0, w_reg};
                        cnt_reg       <= '0;
                        state_reg     <= ST_MUL_TW;
                    end
                end
                ST_MUL_TW:
                begin
                    if (!mul_run)
                    begin
                        neg_reg   <= slope_new_reg[31] ^ b_val[49];
                        mcand_reg <= {32'd0, slope_new_mag};
                        prod_reg  <= {79'd0, b_mag};
                        cnt_reg   <= '0;
                        state_reg <= ST_MUL_CORR;
                    end
                end
                ST_MUL_CORR:
                begin
                    if (!mul_run)
                    begin
                        neg_reg   <= tot_neg;
                        num_reg   <= tot_val << 1;
                        dvs_reg   <= {92'd0, w_reg, 12'd0};
                        rem_reg   <= '0;
                        quo_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_DIV_ANCHOR;
                    end
                end
                ST_DIV_ANCHOR:
                begin
                    if (!div_run)
                    begin
                        slope_reg  <= slope_new_reg;
                        anchor_reg <= anchor_sat;
                        atime_reg  <= t_reg;
                        state_reg  <= ST_FINISH;
                    end
                end
                ST_PRED_SETUP:
                begin
                    neg_reg   <= slope_reg[31] ^ dt[20];
                    mcand_reg <= {32'd0, slope_mag};
                    prod_reg  <= {108'd0, dt_mag};
                    cnt_reg   <= '0;
                    state_reg <= ST_MUL_PRED;
                end
                ST_MUL_PRED:
                begin
                    if (!mul_run)
                    begin
                        x_reg     <= x_val;
                        state_reg <= ST_MOVE;
                    end
                end
                ST_MOVE:
                begin
                    mv_reg     <= mv_sat;
                    status_reg <= fdlf_pkg::STATUS_OK;
                    state_reg  <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (!m_tvalid_reg || m_axis_tready)
                    begin
                        m_tdata_reg  <= {2'd0, mv_reg,
                                         have_model_reg ? anchor_reg : 28'd0,
                                         have_model_reg ? slope_reg : 32'd0};
                        m_tuser_reg  <= {status_reg, have_model_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tuser  = m_tuser_reg;

`ifndef ASSERT_OFF
    a_model_kept: assert property (@(posedge clk) disable iff (!rst_n)
        have_model_reg |=> have_model_reg)
        else $error("Model was lost after it had formed.");
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("A request was accepted while another was in progress.");
    a_no_model_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[2:1] == fdlf_pkg::STATUS_NO_MODEL)
        |-> (!m_axis_tuser[0] && m_axis_tdata[77:0] == 78'd0))
        else $error("A result without a model carries model data.");
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser[2:1] != 2'd3))
        else $error("Result carries an unused status code.");
`endif

endmodule

FILE: tb/focus_drift_line_fit_tb.sv
// Testbench for focus_drift_line_fit: directed and random requests against a predictor.
module focus_drift_line_fit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES  = 4000000;
    localparam int RANDOM_ITEMS  = 830;
    localparam int HOLD_CYCLES   = 3000;
    localparam int HOLD_AT       = 300;
    localparam int DRAIN_CYCLES  = 700;

    typedef struct {
        bit                     valid;
        bit [31:0]              drift;
        bit [27:0]              refpos;
        bit [17:0]              move;
        fdlf_pkg::fit_status_t  status;
    } fit_result_t;

    typedef struct {
        bit                 req;
        bit [19:0]          t;
        bit [15:0]          p;
        bit signed [15:0]   off;
        bit [15:0]          cur;
        bit                 typed;
        fit_result_t        res;
    } fit_request_t;

    logic                               clk;
    logic                               rst_n;
    logic                               s_axis_tvalid;
    logic                               s_axis_tready;
    logic [fdlf_pkg::IN_DATA_BITS-1:0]  s_axis_tdata;
    logic                               s_axis_tuser;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready;
    logic [fdlf_pkg::OUT_DATA_BITS-1:0] m_axis_tdata;
    logic [fdlf_pkg::OUT_USER_BITS-1:0] m_axis_tuser;

    fit_result_t  pending_fits[$];
    fit_request_t directed_rows[$];
    int           errors;
    int           cycles;
    int           accepted;
    int           tx_idle;
    int           rx_idle;
    int           hold_left;
    bit           hold_done;

    // Model state of the line fit.
    bit           has_model;
    bit [23:0]    weight_acc;
    bit [47:0]    time_acc;
    bit [47:0]    pos_acc;
    bit [63:0]    cross_acc;
    bit [63:0]    tsq_acc;
    bit [31:0]    slope_q;
    bit [27:0]    anchor_q;
    bit [19:0]    anchor_t;

    // Random sequence state.
    bit [19:0]    walk_t;
    bit [15:0]    walk_p;

    focus_drift_line_fit u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 clk = ~clk;

    function automatic longint saturate(bit neg, logic [127:0] mag, longint maxpos);
        if (neg)
        begin
            if (mag > 128'(maxpos + 1))
                return -maxpos - 1;
            return -longint'(mag[63:0]);
        end
        if (mag > 128'(maxpos))
            return maxpos;
        return longint'(mag[63:0]);
    endfunction

    function automatic logic [127:0] round_div(logic [127:0] mag, logic [127:0] d);
        logic [127:0] q;
        q = (d == 0) ? 128'd0 : (mag << 1) / d;
        return (q + 128'd1) >> 1;
    endfunction

    function automatic fit_result_t fit_step(fit_request_t rq);
        fit_result_t  r;
        logic [127:0] q1, q2, den, p1, p2, mag, a, c, tot;
        longint       s, b, anc, dt, x, tgt, mv;
        bit           nneg, cneg, tneg;
        r.status = fdlf_pkg::STATUS_OK;
        mv = 0;
        if (rq.req == fdlf_pkg::REQ_ADD)
        begin
            weight_acc = (weight_acc >> 1) + 24'(1 << 20);
            time_acc   = (time_acc >> 1) + (48'(rq.t) << 20);
            pos_acc    = (pos_acc >> 1) + (48'(rq.p) << 20);
            cross_acc  = (cross_acc >> 1) + ((64'(rq.t) * 64'(rq.p)) << 20);
            tsq_acc    = (tsq_acc >> 1) + ((64'(rq.t) * 64'(rq.t)) << 20);
            if (!has_model)
            begin
                has_model = 1'b1;
                slope_q   = '0;
                anchor_q  = 28'(rq.p) << 8;
                anchor_t  = rq.t;
            end
            else
            begin
                q1 = 128'(weight_acc) * 128'(tsq_acc);
                q2 = 128'(time_acc) * 128'(time_acc);
                if (q1 <= q2 || weight_acc == 0)
                    r.status = fdlf_pkg::STATUS_DEGENERATE;
                else
                begin
                    den  = q1 - q2;
                    p1   = 128'(weight_acc) * 128'(cross_acc);
                    p2   = 128'(time_acc) * 128'(pos_acc);
                    nneg = p1 < p2;
                    mag  = nneg ? p2 - p1 : p1 - p2;
                    s    = saturate(nneg, round_div(mag << 20, den), 64'h7FFF_FFFF);
                    a    = 128'(pos_acc) << 20;
                    b    = longint'(rq.t) * longint'(weight_acc) - longint'(time_acc);
                    cneg = (s < 0) != (b < 0);
                    c    = 128'(s < 0 ? -s : s) * 128'(b < 0 ? -b : b);
                    if (!cneg)
                    begin
                        tot  = a + c;
                        tneg = 1'b0;
                    end
                    else if (a >= c)
                    begin
                        tot  = a - c;
                        tneg = 1'b0;
                    end
                    else
                    begin
                        tot  = c - a;
                        tneg = 1'b1;
                    end
                    anc = saturate(tneg, round_div(tot, 128'(weight_acc) << 12),
                                   64'h7FF_FFFF);
                    slope_q  = s[31:0];
                    anchor_q = anc[27:0];
                    anchor_t = rq.t;
                end
            end
        end
        else if (!has_model)
            r.status = fdlf_pkg::STATUS_NO_MODEL;
        else
        begin
            dt  = longint'(rq.t) - longint'(anchor_t);
            x   = longint'($signed(anchor_q)) * 4096 + longint'($signed(slope_q)) * dt
                  + (longint'(1) << 19);
            tgt = x >>> 20;
            mv  = tgt + longint'(rq.off) - longint'(rq.cur);
            if (mv > 131071)
                mv = 131071;
            if (mv < -131072)
                mv = -131072;
        end
        r.valid  = has_model;
        r.drift  = has_model ? slope_q : '0;
        r.refpos = has_model ? anchor_q : '0;
        r.move   = mv[17:0];
        return r;
    endfunction

    task automatic send_request(fit_request_t rq);
        fit_result_t r;
        while ($urandom_range(99) < tx_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= rq.req;
        s_axis_tdata  <= {4'b0, rq.cur, rq.off, rq.p, rq.t};
        do
            @(posedge clk);
        while (!s_axis_tready);
        r = fit_step(rq);
        if (rq.typed)
            r = rq.res;
        pending_fits.insert(pending_fits.size(), r);
        accepted++;
    endtask

    task automatic drain_fits();
        s_axis_tvalid <= 1'b0;
        while (pending_fits.size() > 0)
            @(posedge clk);
    endtask

    task automatic add_row(bit req, bit [19:0] t, bit [15:0] p, bit signed [15:0] off,
                           bit [15:0] cur, bit typed, bit valid, bit [31:0] drift,
                           bit [27:0] refpos, fdlf_pkg::fit_status_t status);
        fit_request_t rq;
        rq.req        = req;
        rq.t          = t;
        rq.p          = p;
        rq.off        = off;
        rq.cur        = cur;
        rq.typed      = typed;
        rq.res.valid  = valid;
        rq.res.drift  = drift;
        rq.res.refpos = refpos;
        rq.res.move   = '0;
        rq.res.status = status;
        directed_rows.insert(directed_rows.size(), rq);
    endtask

    function automatic fit_request_t random_request();
        fit_request_t rq;
        int           pick;
        pick     = $urandom_range(99);
        rq.typed = 1'b0;
        rq.res   = '{default: 0, status: fdlf_pkg::STATUS_OK};
        rq.t     = 20'($urandom);
        rq.p     = 16'($urandom);
        rq.off   = 16'($urandom);
        rq.cur   = 16'($urandom);
        if (pick < 3)
        begin
            walk_t = 20'($urandom);
            walk_p = 16'($urandom);
        end
        if (pick < 48)
        begin
            walk_t = walk_t + 20'($urandom_range(1, 400));
            walk_p = walk_p + 16'($urandom_range(0, 60)) - 16'd30;
            rq.req = fdlf_pkg::REQ_ADD;
            rq.t   = walk_t;
            rq.p   = walk_p;
        end
        else if (pick < 85)
        begin
            rq.req = fdlf_pkg::REQ_PREDICT;
            rq.t   = walk_t + 20'($urandom_range(0, 2000));
            rq.off = 16'($signed($urandom_range(0, 400)) - 200);
            rq.cur = walk_p + 16'($urandom_range(0, 200)) - 16'd100;
        end
        else
            rq.req = 1'($urandom);
        return rq;
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("focus_drift_line_fit test failed");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (!hold_done && accepted >= HOLD_AT)
        begin
            hold_done     <= 1'b1;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= rx_idle);
    end

    always @(posedge clk)
    begin
        fit_result_t e;
        fit_result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.drift  = m_axis_tdata[31:0];
            got.refpos = m_axis_tdata[59:32];
            got.move   = m_axis_tdata[77:60];
            got.valid  = m_axis_tuser[0];
            got.status = fdlf_pkg::fit_status_t'(m_axis_tuser[2:1]);
            if (pending_fits.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: tdata=%h tuser=%h", m_axis_tdata,
                             m_axis_tuser);
            end
            else
            begin
                e = pending_fits.pop_front();
                if (got.valid != e.valid || got.drift != e.drift || got.refpos != e.refpos
                    || got.move != e.move || got.status != e.status)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected v=%0d drift=%h ref=%h move=%h st=%0d",
                                 e.valid, e.drift, e.refpos, e.move, e.status,
                                 ", got v=%0d drift=%h ref=%h move=%h st=%0d",
                                 got.valid, got.drift, got.refpos, got.move, got.status);
                end
            end
        end
    end

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        errors        = 0;
        cycles        = 0;
        accepted      = 0;
        hold_left     = 0;
        hold_done     = 1'b0;
        tx_idle       = 26;
        rx_idle       = 71;
        has_model     = 1'b0;
        weight_acc    = '0;
        time_acc      = '0;
        pos_acc       = '0;
        cross_acc     = '0;
        tsq_acc       = '0;
        slope_q       = '0;
        anchor_q      = '0;
        anchor_t      = '0;
        walk_t        = 20'd100;
        walk_p        = 16'd30000;

        add_row(fdlf_pkg::REQ_PREDICT, 20'hFFFFF, 16'hFFFF, -16'sd32768, 16'hFFFF, 1, 0, 0, 0,
                fdlf_pkg::STATUS_NO_MODEL);
        add_row(fdlf_pkg::REQ_ADD, 20'h0, 16'hFFFF, 0, 0, 1, 1, 0, 28'hFFFF00,
                fdlf_pkg::STATUS_OK);
        add_row(fdlf_pkg::REQ_ADD, 20'h0, 16'h0, 0, 0, 1, 1, 0, 28'hFFFF00,
                fdlf_pkg::STATUS_DEGENERATE);
        add_row(fdlf_pkg::REQ_PREDICT, 20'h0, 16'h0, 16'sd0, 16'h0, 0, 0, 0, 0,
                fdlf_pkg::STATUS_OK);
        add_row(fdlf_pkg::REQ_ADD, 20'h10, 16'd100, 0, 0, 0, 0, 0, 0, fdlf_pkg::STATUS_OK);
        add_row(fdlf_pkg::REQ_ADD, 20'hFFFFF, 16'hFFFF, 0, 0, 0, 0, 0, 0,
                fdlf_pkg::STATUS_OK);
        add_row(fdlf_pkg::REQ_PREDICT, 20'hFFFFF, 16'h0, 16'sd32767, 16'h0, 0, 0, 0, 0,
                fdlf_pkg::STATUS_OK);
        add_row(fdlf_pkg::REQ_PREDICT, 20'h0, 16'h0, -16'sd32768, 16'hFFFF, 0, 0, 0, 0,
                fdlf_pkg::STATUS_OK);
        add_row(fdlf_pkg::REQ_ADD, 20'hFFFFF, 16'h0, 0, 0, 0, 0, 0, 0, fdlf_pkg::STATUS_OK);
        add_row(fdlf_pkg::REQ_ADD, 20'hFFFFF, 16'h0, 0, 0, 0, 0, 0, 0, fdlf_pkg::STATUS_OK);
        add_row(fdlf_pkg::REQ_PREDICT, 20'h80000, 16'h0, -16'sd1, 16'h8000, 0, 0, 0, 0,
                fdlf_pkg::STATUS_OK);
        add_row(fdlf_pkg::REQ_ADD, 20'h1, 16'h1, 0, 0, 0, 0, 0, 0, fdlf_pkg::STATUS_OK);
        add_row(fdlf_pkg::REQ_ADD, 20'h2, 16'hFFFF, 0, 0, 0, 0, 0, 0, fdlf_pkg::STATUS_OK);
        add_row(fdlf_pkg::REQ_PREDICT, 20'hFFFFF, 16'h5555, 16'sh2AAA, 16'hAAAA, 0, 0, 0, 0,
                fdlf_pkg::STATUS_OK);
        add_row(fdlf_pkg::REQ_PREDICT, 20'h55555, 16'hAAAA, -16'sh2AAB, 16'h5555, 0, 0, 0, 0,
                fdlf_pkg::STATUS_OK);
        add_row(fdlf_pkg::REQ_ADD, 20'hAAAAA, 16'h5555, 0, 0, 0, 0, 0, 0,
                fdlf_pkg::STATUS_OK);
        add_row(fdlf_pkg::REQ_ADD, 20'h55555, 16'hAAAA, 0, 0, 0, 0, 0, 0,
                fdlf_pkg::STATUS_OK);
        add_row(fdlf_pkg::REQ_PREDICT, 20'h0, 16'h0, 16'sd0, 16'h0, 0, 0, 0, 0,
                fdlf_pkg::STATUS_OK);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i]);
        drain_fits();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 3)
            begin
                drain_fits();
                tx_idle = 71;
                rx_idle = 26;
            end
            else if (n == 2 * RANDOM_ITEMS / 3)
            begin
                drain_fits();
                tx_idle = 0;
                rx_idle = 0;
            end
            send_request(random_request());
        end
        drain_fits();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && pending_fits.size() == 0)
            $display("focus_drift_line_fit test passed");
        else
            $display("focus_drift_line_fit test failed");
        $finish;
    end
endmodule
